### hw/rtl/wrg_pkg.sv
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types and constants for the WELL512a generator core.
// ----------------------------------------------------------------------------
package wrg_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned POOL_DEPTH = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned DIV_CNT_W  = 5;

	// WELL512a taps, relative to the current ring word
	localparam int unsigned TAP_A     = 13;
	localparam int unsigned TAP_B     = 9;
	localparam int unsigned TAP_BACK  = 15;
	localparam int unsigned XOR_SHIFT = 11;
	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda44_2d24;
	localparam logic [WORD_W-1:0] SEED_BASE   = 32'd5;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_RAW    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RANGED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEED   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_DIVIDE,
		ST_FINISH
	} wrg_state_t;

	typedef struct packed {
		logic capture;
		logic seed_write;
		logic step;
		logic div_step;
		logic out_load;
	} wrg_cmd_t;

	typedef struct packed {
		logic need_divide;
		logic div_done;
	} wrg_status_t;

endpackage

### hw/rtl/well512_random_generator_core.sv
// ----------------------------------------------------------------------------
// well512_random_generator_core
// WELL512a generator with raw draws, ranged draws and seed-word loads.
// Input channel (in_valid/in_ready) carries one beat per request: kind 0
//   draws a raw word, kind 1 draws low_bound + raw mod (high_bound -
//   low_bound), kind 2 writes seed_word into ring word seed_index, kind 3
//   is ignored. Seed loads and kind 3 give no output beat.
// Output channel (out_valid/out_ready) carries value and span_error; a
//   ranged draw with zero span returns the raw word with span_error set.
// Steps: a draw advances the generator in ST_STEP; a ranged draw with
//   nonzero span then runs the bit-serial remainder unit in ST_DIVIDE,
//   and ST_FINISH loads the result. A seed load writes when accepted.
// The block takes one request at a time; in_ready is high while idle.
// A stalled receiver holds the result register; the next request is
//   still taken and runs up to its result, then waits for the slot.
// Reset loads ring words 5..20 and ring index 0; no clearing pass.
// ----------------------------------------------------------------------------
module well512_random_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [wrg_pkg::KIND_W-1:0]        kind,
	input  logic [wrg_pkg::WORD_W-1:0]        low_bound,
	input  logic [wrg_pkg::WORD_W-1:0]        high_bound,
	input  logic [wrg_pkg::IDX_W-1:0]         seed_index,
	input  logic [wrg_pkg::WORD_W-1:0]        seed_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wrg_pkg::WORD_W-1:0]        value,
	output logic                              span_error
);

	// command and status between sequencer and datapath
	wrg_pkg::wrg_cmd_t    cmd;
	wrg_pkg::wrg_status_t status;

	wrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	wrg_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (kind),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.seed_index (seed_index),
		.seed_word  (seed_word),
		.value      (value),
		.span_error (span_error)
	);

endmodule

### hw/rtl/wrg_datapath.sv
// ----------------------------------------------------------------------------
// wrg_datapath
// Rotating state ring, WELL512a step, serial remainder unit, result register.
// ----------------------------------------------------------------------------
module wrg_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wrg_pkg::wrg_cmd_t                 cmd,
	output wrg_pkg::wrg_status_t              status,
	input  logic [wrg_pkg::KIND_W-1:0]        kind,
	input  logic [wrg_pkg::WORD_W-1:0]        low_bound,
	input  logic [wrg_pkg::WORD_W-1:0]        high_bound,
	input  logic [wrg_pkg::IDX_W-1:0]         seed_index,
	input  logic [wrg_pkg::WORD_W-1:0]        seed_word,
	output logic [wrg_pkg::WORD_W-1:0]        value,
	output logic                              span_error
);

	// pool_q[0] is always the current ring word; ring_q tracks its absolute index
	logic [wrg_pkg::WORD_W-1:0]    pool_q [wrg_pkg::POOL_DEPTH];
	logic [wrg_pkg::IDX_W-1:0]     ring_q;
	logic [wrg_pkg::IDX_W-1:0]     seed_pos;

	logic [wrg_pkg::WORD_W-1:0]    low_q;
	logic [wrg_pkg::WORD_W-1:0]    span_q;
	logic                          ranged_q;
	logic [wrg_pkg::WORD_W-1:0]    raw_q;
	logic [wrg_pkg::WORD_W-1:0]    rem_q;
	logic [wrg_pkg::WORD_W-1:0]    dvd_q;
	logic [wrg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [wrg_pkg::WORD_W-1:0]    value_q;
	logic                          err_q;

	logic [wrg_pkg::WORD_W-1:0] x, y, z0, z, back, mix, fresh, tempered, final_w;
	logic [wrg_pkg::WORD_W:0]   trial;
	logic [wrg_pkg::WORD_W:0]   trial_diff;
	logic                       span_zero;

	always_comb begin
		x        = pool_q[0];
		y        = pool_q[wrg_pkg::TAP_A];
		z0       = pool_q[wrg_pkg::TAP_B];
		back     = pool_q[wrg_pkg::TAP_BACK];
		mix      = x ^ y ^ (x << 16) ^ (y << 15);
		z        = z0 ^ (z0 >> wrg_pkg::XOR_SHIFT);
		fresh    = mix ^ z;
		tempered = fresh ^ ((fresh << 5) & wrg_pkg::TEMPER_MASK);
		final_w  = back ^ mix ^ tempered ^ (back << 2) ^ (mix << 18) ^ (z << 28);
	end

	assign seed_pos = seed_index - ring_q;

	// ring: a step moves the current index back by one, so the array rotates up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < wrg_pkg::POOL_DEPTH; k++) begin
				pool_q[k] <= wrg_pkg::SEED_BASE + wrg_pkg::WORD_W'(k);
			end
			ring_q <= '0;
		end else if (cmd.step) begin
			pool_q[0] <= final_w;
			pool_q[1] <= fresh;
			for (int k = 2; k < wrg_pkg::POOL_DEPTH; k++) begin
				pool_q[k] <= pool_q[k-1];
			end
			ring_q <= ring_q - 1'b1;
		end else if (cmd.seed_write) begin
			pool_q[seed_pos] <= seed_word;
		end
	end

	// restoring remainder, one bit a cycle
	assign trial      = {rem_q, dvd_q[wrg_pkg::WORD_W-1]};
	assign trial_diff = trial - {1'b0, span_q};
	assign span_zero  = (span_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			low_q    <= low_bound;
			span_q   <= high_bound - low_bound;
			ranged_q <= (kind == wrg_pkg::KIND_RANGED);
		end
		if (cmd.step) begin
			raw_q <= final_w;
			dvd_q <= final_w;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= trial_diff[wrg_pkg::WORD_W] ? trial[wrg_pkg::WORD_W-1:0]
			                                     : trial_diff[wrg_pkg::WORD_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (ranged_q && !span_zero) begin
				value_q <= low_q + rem_q;
				err_q   <= 1'b0;
			end else begin
				value_q <= raw_q;
				err_q   <= ranged_q;
			end
		end
	end

	assign status.need_divide = ranged_q && !span_zero;
	assign status.div_done    = &cnt_q;
	assign value              = value_q;
	assign span_error         = err_q;

endmodule

### hw/rtl/wrg_ctrl.sv
// ----------------------------------------------------------------------------
// wrg_ctrl
// Sequencer for draws and seed loads; owns the handshakes.
// ----------------------------------------------------------------------------
module wrg_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [wrg_pkg::KIND_W-1:0] kind,
	output logic                       out_valid,
	input  logic                       out_ready,
	output wrg_pkg::wrg_cmd_t          cmd,
	input  wrg_pkg::wrg_status_t       status
);

	wrg_pkg::wrg_state_t state_q, state_d;
	logic                out_valid_q;
	logic                accept;
	logic                is_draw;
	logic                slot_free;

	assign accept    = in_valid && in_ready;
	assign is_draw   = (kind == wrg_pkg::KIND_RAW) || (kind == wrg_pkg::KIND_RANGED);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wrg_pkg::ST_IDLE: begin
				if (accept && is_draw) state_d = wrg_pkg::ST_STEP;
			end
			wrg_pkg::ST_STEP: begin
				state_d = status.need_divide ? wrg_pkg::ST_DIVIDE : wrg_pkg::ST_FINISH;
			end
			wrg_pkg::ST_DIVIDE: begin
				if (status.div_done) state_d = wrg_pkg::ST_FINISH;
			end
			wrg_pkg::ST_FINISH: begin
				if (slot_free) state_d = wrg_pkg::ST_IDLE;
			end
			default: state_d = wrg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wrg_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.capture    = accept;
				cmd.seed_write = accept && (kind == wrg_pkg::KIND_SEED);
			end
			wrg_pkg::ST_STEP:   cmd.step     = 1'b1;
			wrg_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
			wrg_pkg::ST_FINISH: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wrg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)    out_valid_q <= 1'b1;
			else if (out_ready)  out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a draw always starts with the generator step
	a_draw_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_draw |=> state_q == wrg_pkg::ST_STEP)
		else $error("draw did not enter step");

	// seed loads and unused kinds leave the sequencer idle
	a_seed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_draw |=> state_q == wrg_pkg::ST_IDLE)
		else $error("non-draw left idle");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

	// last remainder bit leads straight to the result
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wrg_pkg::ST_DIVIDE && status.div_done |=> state_q == wrg_pkg::ST_FINISH)
		else $error("remainder did not finish");

endmodule
